[hw/rtl/cte_pkg.sv]
// Shared types, constants and fixed-point helpers for the covariance taper evaluator.
package cte_pkg;

   localparam int QB         = 24;               // fraction bits of internal values
   localparam int VW         = 40;               // internal signed value width
   localparam int NW         = 28;               // narrow multiplier operand width
   localparam int XW         = 24;               // distance inside the support, Q24
   localparam int TW         = 25;               // Storkey angle width
   localparam int QW         = 26;               // width of t2 and its quotients
   localparam int MW         = 27;               // reciprocal width
   localparam int MAW        = 33;               // magnitude bits used of a wide operand
   localparam int MBW        = NW - 1;           // magnitude bits of a narrow operand
   localparam int PW         = MAW + MBW;
   localparam int HW         = 18;               // input field width
   localparam int CW         = 17;               // output field width
   localparam int NUM_STAGES = 13;

   typedef logic signed [VW-1:0] val_type;
   typedef logic signed [NW-1:0] nar_type;

   localparam val_type ONE = 40'sd16777216;

   typedef enum logic [2:0] {
      TK_SPHERICAL = 3'd0,
      TK_CUBIC     = 3'd1,
      TK_TRIANGLE  = 3'd2,
      TK_PENTA     = 3'd3,
      TK_STORKEY   = 3'd4,
      TK_WENDLAND1 = 3'd5,
      TK_WENDLAND2 = 3'd6
   } taper_kind_type;

   // Reciprocals for exact truncating division of a QW-bit value by a constant
   localparam int D6_S   = 29;
   localparam int D12_S  = 30;
   localparam int D20_S  = 31;
   localparam int D30_S  = 31;
   localparam int D42_S  = 32;
   localparam int D56_S  = 32;
   localparam int D72_S  = 33;
   localparam int D90_S  = 33;
   localparam int D110_S = 33;
   localparam int D132_S = 34;
   localparam logic [MW-1:0] D6_M   = MW'(((64'd1 << D6_S)   + 64'd5)   / 64'd6);
   localparam logic [MW-1:0] D12_M  = MW'(((64'd1 << D12_S)  + 64'd11)  / 64'd12);
   localparam logic [MW-1:0] D20_M  = MW'(((64'd1 << D20_S)  + 64'd19)  / 64'd20);
   localparam logic [MW-1:0] D30_M  = MW'(((64'd1 << D30_S)  + 64'd29)  / 64'd30);
   localparam logic [MW-1:0] D42_M  = MW'(((64'd1 << D42_S)  + 64'd41)  / 64'd42);
   localparam logic [MW-1:0] D56_M  = MW'(((64'd1 << D56_S)  + 64'd55)  / 64'd56);
   localparam logic [MW-1:0] D72_M  = MW'(((64'd1 << D72_S)  + 64'd71)  / 64'd72);
   localparam logic [MW-1:0] D90_M  = MW'(((64'd1 << D90_S)  + 64'd89)  / 64'd90);
   localparam logic [MW-1:0] D110_M = MW'(((64'd1 << D110_S) + 64'd109) / 64'd110);
   localparam logic [MW-1:0] D132_M = MW'(((64'd1 << D132_S) + 64'd131) / 64'd132);

   typedef struct packed {
      logic [XW-1:0] x;
      val_type       h2;
      logic [TW-1:0] t;
      logic [1:0]    quad;
      logic          oos;
   } front_type;

   typedef struct packed {
      logic [QW-1:0] q2;
      logic [QW-1:0] q6;
      logic [QW-1:0] q12;
      logic [QW-1:0] q20;
      logic [QW-1:0] q30;
      logic [QW-1:0] q42;
      logic [QW-1:0] q56;
      logic [QW-1:0] q72;
      logic [QW-1:0] q90;
      logic [QW-1:0] q110;
      logic [QW-1:0] q132;
   } quot_type;

   // Q24 product, rounded half away from zero
   function automatic val_type mulq(input val_type a, input nar_type b);
      logic [VW-1:0] ua;
      logic [NW-1:0] ub;
      logic [PW-1:0] p;
      logic          neg;
      val_type       mv;
      neg = a[VW-1] ^ b[NW-1];
      ua  = a[VW-1] ? (~a + 1'b1) : a;
      ub  = b[NW-1] ? (~b + 1'b1) : b;
      p   = ({{MBW{1'b0}}, ua[MAW-1:0]} * {{MAW{1'b0}}, ub[MBW-1:0]})
            + (PW'(1) << (QB - 1));
      mv  = val_type'(p[PW-1:QB]);
      return neg ? -mv : mv;
   endfunction

   function automatic logic [QW-1:0] divk(input logic [QW-1:0] n, input logic [MW-1:0] m,
                                          input int s);
      logic [QW+MW-1:0] p;
      p = {{MW{1'b0}}, n} * {{QW{1'b0}}, m};
      return QW'(p >> s);
   endfunction

   function automatic val_type widen(input logic [XW-1:0] v);
      return $signed({{(VW-XW){1'b0}}, v});
   endfunction

   function automatic nar_type narrow(input val_type v);
      return $signed(v[NW-1:0]);
   endfunction

endpackage

[hw/rtl/cte_front.sv]
// Input conditioning: support check, Q24 conversion, h squared and Storkey angle.
module cte_front import cte_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic [NUM_STAGES-1:0] adv,
   input  logic [HW-1:0]         h,
   output front_type             fr
);

   localparam int SHL = (FRAC_BITS <= QB) ? (QB - FRAC_BITS) : 0;
   localparam int SHR = (FRAC_BITS > QB) ? (FRAC_BITS - QB) : 0;
   localparam logic [31:0] LIMIT = 32'd1 << FRAC_BITS;
   localparam int RW = XW - 2;
   localparam int TPW = RW + MW;
   localparam logic [MW-1:0] TWO_PI = 27'd105414357;

   logic [47:0]     hx;
   logic [XW-1:0]   x_ff;
   logic [XW-1:0]   x_in;
   logic            oos_ff;
   logic            oos_in;
   logic [TPW-1:0]  tp;
   front_type       fr_ff;
   front_type       fr_in;

   always_comb begin
      hx     = ({30'd0, h} << SHL) >> SHR;
      x_in   = hx[XW-1:0];
      oos_in = ({14'd0, h} >= LIMIT);
   end

   always_comb begin
      tp         = ({{MW{1'b0}}, x_ff[RW-1:0]} * {{RW{1'b0}}, TWO_PI}) + (TPW'(1) << (QB - 1));
      fr_in.x    = x_ff;
      fr_in.h2   = mulq(widen(x_ff), narrow(widen(x_ff)));
      fr_in.t    = tp[TPW-1:QB];
      fr_in.quad = x_ff[XW-1:XW-2];
      fr_in.oos  = oos_ff;
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         x_ff   <= x_in;
         oos_ff <= oos_in;
      end
      if (adv[1]) begin
         fr_ff <= fr_in;
      end
   end

   assign fr = fr_ff;

endmodule

[hw/rtl/cte_trig.sv]
// Storkey taper: sin and cos of the phase by nested series, quadrant fold, combine.
module cte_trig import cte_pkg::*; (
   input  logic                  clock,
   input  logic [NUM_STAGES-1:0] adv,
   input  front_type             fr,
   output val_type               vst
);

   logic [TW-1:0] t_ff [2:7];
   logic [1:0]    quad_ff [2:8];
   val_type       g_ff [2:10];
   val_type       t2_ff;
   val_type       t2_in;
   val_type       g_in;
   quot_type      q_ff [3:7];
   quot_type      q_in;
   val_type       sp_ff [4:7];
   val_type       sp_in [4:7];
   val_type       cp_ff [4:7];
   val_type       cp_in [4:7];
   val_type       s_ff, s_in, c_ff, c_in;
   val_type       sn_ff, sn_in, cs_ff, cs_in;
   val_type       hc_ff, hc_in, sc_ff, sc_in;
   val_type       v_ff, v_in;
   logic [QW-1:0] t2u;

   function automatic nar_type nq(input logic [QW-1:0] q);
      return $signed({{(NW-QW){1'b0}}, q});
   endfunction

   always_comb begin
      t2_in = mulq($signed({{(VW-TW){1'b0}}, fr.t}), $signed({{(NW-TW){1'b0}}, fr.t}));
      g_in  = mulq(ONE - widen(fr.x), 28'sd11184811);

      t2u       = t2_ff[QW-1:0];
      q_in.q2   = t2u >> 1;
      q_in.q6   = divk(t2u, D6_M, D6_S);
      q_in.q12  = divk(t2u, D12_M, D12_S);
      q_in.q20  = divk(t2u, D20_M, D20_S);
      q_in.q30  = divk(t2u, D30_M, D30_S);
      q_in.q42  = divk(t2u, D42_M, D42_S);
      q_in.q56  = divk(t2u, D56_M, D56_S);
      q_in.q72  = divk(t2u, D72_M, D72_S);
      q_in.q90  = divk(t2u, D90_M, D90_S);
      q_in.q110 = divk(t2u, D110_M, D110_S);
      q_in.q132 = divk(t2u, D132_M, D132_S);

      sp_in[4] = ONE - mulq(ONE - $signed({{(VW-QW){1'b0}}, q_ff[3].q110}), nq(q_ff[3].q72));
      cp_in[4] = ONE - mulq(ONE - $signed({{(VW-QW){1'b0}}, q_ff[3].q132}), nq(q_ff[3].q90));
      sp_in[5] = ONE - mulq(sp_ff[4], nq(q_ff[4].q42));
      cp_in[5] = ONE - mulq(cp_ff[4], nq(q_ff[4].q56));
      sp_in[6] = ONE - mulq(sp_ff[5], nq(q_ff[5].q20));
      cp_in[6] = ONE - mulq(cp_ff[5], nq(q_ff[5].q30));
      sp_in[7] = ONE - mulq(sp_ff[6], nq(q_ff[6].q6));
      cp_in[7] = ONE - mulq(cp_ff[6], nq(q_ff[6].q12));
      s_in     = mulq(sp_ff[7], $signed({{(NW-TW){1'b0}}, t_ff[7]}));
      c_in     = ONE - mulq(cp_ff[7], nq(q_ff[7].q2));

      // fold the quarter wave into the full turn
      case (quad_ff[8])
         2'd0: begin
            sn_in = s_ff;
            cs_in = c_ff;
         end
         2'd1: begin
            sn_in = c_ff;
            cs_in = -s_ff;
         end
         2'd2: begin
            sn_in = -s_ff;
            cs_in = -c_ff;
         end
         default: begin
            sn_in = -c_ff;
            cs_in = s_ff;
         end
      endcase

      hc_in = mulq(cs_ff, 28'sd8388608);
      sc_in = mulq(sn_ff, 28'sd2670177);
      v_in  = mulq(ONE + hc_ff, narrow(g_ff[10])) + sc_ff;
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         t_ff[2]    <= fr.t;
         quad_ff[2] <= fr.quad;
         g_ff[2]    <= g_in;
         t2_ff      <= t2_in;
      end
      for (int k = 3; k <= 7; k++) begin
         if (adv[k]) begin
            t_ff[k] <= t_ff[k-1];
         end
      end
      for (int k = 3; k <= 8; k++) begin
         if (adv[k]) begin
            quad_ff[k] <= quad_ff[k-1];
         end
      end
      for (int k = 3; k <= 10; k++) begin
         if (adv[k]) begin
            g_ff[k] <= g_ff[k-1];
         end
      end
      if (adv[3]) begin
         q_ff[3] <= q_in;
      end
      for (int k = 4; k <= 7; k++) begin
         if (adv[k]) begin
            q_ff[k] <= q_ff[k-1];
         end
      end
      for (int k = 4; k <= 7; k++) begin
         if (adv[k]) begin
            sp_ff[k] <= sp_in[k];
            cp_ff[k] <= cp_in[k];
         end
      end
      if (adv[8]) begin
         s_ff <= s_in;
         c_ff <= c_in;
      end
      if (adv[9]) begin
         sn_ff <= sn_in;
         cs_ff <= cs_in;
      end
      if (adv[10]) begin
         hc_ff <= hc_in;
         sc_ff <= sc_in;
      end
      if (adv[11]) begin
         v_ff <= v_in;
      end
   end

   assign vst = v_ff;

endmodule

[hw/rtl/cte_poly.sv]
// Horner lanes for the polynomial tapers and selection of the configured one.
module cte_poly import cte_pkg::*; (
   input  logic                  clock,
   input  logic [NUM_STAGES-1:0] adv,
   input  front_type             fr,
   input  logic [2:0]            kind,
   output val_type               vpl
);

   typedef struct packed {
      logic [XW-1:0] x;
      val_type       h2;
      val_type       aux;
      val_type       sph;
      val_type       cub;
      val_type       pen;
      val_type       wd1;
      val_type       wd2;
   } lane_type;

   lane_type pl_ff [2:7];
   lane_type pl_in [2:7];
   val_type  sel_ff [8:11];
   val_type  sel_in;

   always_comb begin
      pl_in[2].x   = fr.x;
      pl_in[2].h2  = fr.h2;
      pl_in[2].sph = mulq(40'sd8388608, narrow(widen(fr.x)));
      pl_in[2].aux = 40'sd50331648 - fr.h2;
      pl_in[2].cub = 40'sd58720256 - mulq(fr.h2, 28'sd12582912);
      pl_in[2].pen = 40'sd92274688 - mulq(fr.h2, 28'sd13981013);
      pl_in[2].wd1 = 40'sd251658240 - mulq(widen(fr.x), 28'sd67108864);
      pl_in[2].wd2 = 40'sd1073741824 - mulq(40'sd195734187, narrow(widen(fr.x)));

      for (int k = 3; k <= 7; k++) begin
         pl_in[k] = pl_ff[k-1];
      end

      pl_in[3].sph = ONE - mulq(pl_ff[2].sph, narrow(pl_ff[2].aux));
      pl_in[3].cub = -40'sd146800640 + mulq(pl_ff[2].cub, narrow(pl_ff[2].h2));
      pl_in[3].pen = 40'sd276824064 - mulq(pl_ff[2].pen, narrow(pl_ff[2].h2));
      pl_in[3].wd1 = 40'sd335544320 - mulq(pl_ff[2].wd1, narrow(widen(pl_ff[2].x)));
      pl_in[3].wd2 = 40'sd2348810240 - mulq(pl_ff[2].wd2, narrow(widen(pl_ff[2].x)));

      pl_in[4].cub = 40'sd117440512 + mulq(pl_ff[3].cub, narrow(widen(pl_ff[3].x)));
      pl_in[4].pen = 40'sd645922816 - mulq(pl_ff[3].pen, narrow(pl_ff[3].h2));
      pl_in[4].wd1 = 40'sd167772160 - mulq(pl_ff[3].wd1, narrow(widen(pl_ff[3].x)));
      pl_in[4].wd2 = 40'sd2505397589 - mulq(pl_ff[3].wd2, narrow(widen(pl_ff[3].x)));

      pl_in[5].cub = ONE - mulq(pl_ff[4].cub, narrow(pl_ff[4].h2));
      pl_in[5].pen = 40'sd553648128 - mulq(pl_ff[4].pen, narrow(widen(pl_ff[4].x)));
      pl_in[5].wd1 = ONE - mulq(pl_ff[4].wd1, narrow(pl_ff[4].h2));
      pl_in[5].wd2 = 40'sd1174405120 - mulq(pl_ff[4].wd2, narrow(widen(pl_ff[4].x)));

      pl_in[6].pen = 40'sd123032917 - mulq(pl_ff[5].pen, narrow(pl_ff[5].h2));
      pl_in[6].wd2 = 40'sd156587349 - mulq(pl_ff[5].wd2, narrow(pl_ff[5].h2));

      pl_in[7].pen = ONE - mulq(pl_ff[6].pen, narrow(pl_ff[6].h2));
      pl_in[7].wd2 = ONE - mulq(pl_ff[6].wd2, narrow(pl_ff[6].h2));

      case (kind)
         TK_SPHERICAL: sel_in = pl_ff[7].sph;
         TK_CUBIC:     sel_in = pl_ff[7].cub;
         TK_TRIANGLE:  sel_in = ONE - widen(pl_ff[7].x);
         TK_PENTA:     sel_in = pl_ff[7].pen;
         TK_WENDLAND1: sel_in = pl_ff[7].wd1;
         TK_WENDLAND2: sel_in = pl_ff[7].wd2;
         default:      sel_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      for (int k = 2; k <= 7; k++) begin
         if (adv[k]) begin
            pl_ff[k] <= pl_in[k];
         end
      end
      if (adv[8]) begin
         sel_ff[8] <= sel_in;
      end
      for (int k = 9; k <= 11; k++) begin
         if (adv[k]) begin
            sel_ff[k] <= sel_ff[k-1];
         end
      end
   end

   assign vpl = sel_ff[11];

endmodule

[hw/rtl/covariance_taper_eval.sv]
// Covariance taper evaluator: one distance in, one taper value out, thirteen stages deep.
//
// Each transfer on req carries a distance h with FRAC_BITS fraction bits; each transfer on rsp
// returns the taper value in Q1.16, clamped to [0, 1], and zero for h of 1.0 or more. The taper
// is picked by the 3-bit register written over the csr channel (0 spherical, 1 cubic, 2 triangle,
// 3 penta, 4 Storkey, 5 Wendland1, 6 Wendland2, 7 gives zero); write it only while no item is in
// flight. The block takes one item per clock while rsp is not stalled; its pipeline depth is set
// by the Storkey path, whose sin and cos series form the longest chain of registered multipliers.
// Every stage has its own valid bit, so empty stages fill while rsp is stalled.
module covariance_taper_eval import cte_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [17:0] h, [23:18] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [16:0] cov, [23:17] zero
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_wdata    // taper kind
);

   localparam int LAST = NUM_STAGES - 1;

   logic [NUM_STAGES-1:0] vld_ff;
   logic [NUM_STAGES-1:0] vld_in;
   logic [NUM_STAGES-1:0] adv;
   logic [2:0]            kind_ff;
   front_type             fr;
   val_type               vst;
   val_type               vpl;
   logic                  oos_ff [2:LAST-1];
   val_type               v;
   logic [CW-1:0]         cov_ff;
   logic [CW-1:0]         cov_in;
   logic [TW-1:0]         vr;

   cte_front #(
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock (clock),
      .adv   (adv),
      .h     (req_tdata[HW-1:0]),
      .fr    (fr)
   );

   cte_trig u_trig (
      .clock (clock),
      .adv   (adv),
      .fr    (fr),
      .vst   (vst)
   );

   cte_poly u_poly (
      .clock (clock),
      .adv   (adv),
      .fr    (fr),
      .kind  (kind_ff),
      .vpl   (vpl)
   );

   // a stage advances when it is empty or the one after it advances
   always_comb begin
      adv[LAST] = !vld_ff[LAST] || rsp_tready;
      for (int i = LAST - 1; i >= 0; i--) begin
         adv[i] = !vld_ff[i] || adv[i+1];
      end
      vld_in = {vld_ff[LAST-1:0], req_tvalid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= '0;
         kind_ff <= TK_SPHERICAL;
      end else begin
         for (int i = 0; i < NUM_STAGES; i++) begin
            if (adv[i]) begin
               vld_ff[i] <= vld_in[i];
            end
         end
         if (csr_valid) begin
            kind_ff <= csr_wdata;
         end
      end
   end

   always_comb begin
      v = (kind_ff == TK_STORKEY) ? vst : vpl;
      if (v < 0) begin
         vr = '0;
      end else if (v > ONE) begin
         vr = ONE[TW-1:0];
      end else begin
         vr = v[TW-1:0];
      end
      cov_in = oos_ff[LAST-1] ? '0 : CW'((vr + TW'(128)) >> 8);
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         oos_ff[2] <= fr.oos;
      end
      for (int k = 3; k <= LAST - 1; k++) begin
         if (adv[k]) begin
            oos_ff[k] <= oos_ff[k-1];
         end
      end
      if (adv[LAST]) begin
         cov_ff <= cov_in;
      end
   end

   assign req_tready = adv[0];
   assign rsp_tvalid = vld_ff[LAST];
   assign rsp_tdata  = {7'd0, cov_ff};
   assign csr_ready  = 1'b1;

endmodule
